// ----- src/pls_pkg.sv -----
// Shared types and constants for the point light pixel shader.
package pls_pkg;

  localparam int unsigned PixW   = 32;
  localparam int unsigned CoordW = 12;
  localparam int unsigned LightW = 14;
  localparam int unsigned FixW   = 32;
  localparam int unsigned ColW   = 8;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned InW    = 56;
  localparam int unsigned DeltaW = 15;
  localparam int unsigned SqW    = 28;
  localparam int unsigned D2W    = 29;
  localparam int unsigned DenW   = 62;
  localparam int unsigned DivW   = 41;
  localparam int unsigned KW     = 24;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  localparam logic [IdxW-1:0] RegLightX = 3'd0;
  localparam logic [IdxW-1:0] RegLightY = 3'd1;
  localparam logic [IdxW-1:0] RegScale  = 3'd2;
  localparam logic [IdxW-1:0] RegInvInt = 3'd3;
  localparam logic [IdxW-1:0] RegRed    = 3'd4;
  localparam logic [IdxW-1:0] RegGreen  = 3'd5;
  localparam logic [IdxW-1:0] RegBlue   = 3'd6;

  typedef struct packed {
    logic [PixW-1:0]   pixel;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic              bypass;
  } item_t;

  typedef struct packed {
    logic signed [LightW-1:0] light_x;
    logic signed [LightW-1:0] light_y;
    logic [FixW-1:0]          scale;
    logic [FixW-1:0]          inv_int;
    logic [ColW-1:0]          red;
    logic [ColW-1:0]          green;
    logic [ColW-1:0]          blue;
  } light_cfg_t;

endpackage

// ----- src/pls_front.sv -----
// Input stage: takes transfers and marks shadowed pixels for pass-through.
module pls_front import pls_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [InW-1:0] in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output item_t          out_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_ready_o  = ~valid_q | out_ready_i;
  assign take        = in_valid_i & in_ready_o;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d       = 1'b1;
      item_d.pixel  = in_data_i[PixW-1:0];
      item_d.column = in_data_i[PixW+CoordW-1:PixW];
      item_d.row    = in_data_i[PixW+2*CoordW-1:PixW+CoordW];
      item_d.bypass = |in_data_i[PixW-1:0];
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ----- src/pls_queue.sv -----
// Short queue between the front and the shading pipeline.
module pls_queue import pls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCntW'(QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push & ~pop) cnt_q <= cnt_q + 1'b1;
      else if (pop & ~push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule

// ----- src/pls_back.sv -----
// Shading pipeline: distance, denominator, radix-2 reciprocal, color scaling.
module pls_back import pls_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  light_cfg_t      cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  item_t           in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] out_pixel_o
);

  logic en;
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // stage 1: deltas
  logic                     v1_q;
  logic [PixW-1:0]          p1_q;
  logic                     b1_q;
  logic signed [DeltaW-1:0] dx_q, dy_q;
  // stage 2: squares
  logic                     v2_q;
  logic [PixW-1:0]          p2_q;
  logic                     b2_q;
  logic [SqW-1:0]           sqx_q, sqy_q;
  // stage 3: distance squared
  logic                     v3_q;
  logic [PixW-1:0]          p3_q;
  logic                     b3_q;
  logic [D2W-1:0]           d2_q;
  // stage 4: partial products
  logic                     v4_q;
  logic [PixW-1:0]          p4_q;
  logic                     b4_q;
  logic [FixW+16-1:0]       plo_q;
  logic [FixW+13-1:0]       phi_q;
  // stage 5: denominator
  logic                     v5_q;
  logic [PixW-1:0]          p5_q;
  logic                     b5_q;
  logic                     sat5_q;
  logic [DivW-1:0]          den5_q;
  // divider stages
  logic                     vd_q   [KW];
  logic [PixW-1:0]          pd_q   [KW];
  logic                     bd_q   [KW];
  logic                     satd_q [KW];
  logic [DivW-1:0]          dend_q [KW];
  logic [DivW-1:0]          rem_q  [KW];
  logic [KW-1:0]            quo_q  [KW];
  logic [DivW-1:0]          rem_d  [KW];
  logic [KW-1:0]            quo_d  [KW];
  // product stage
  logic                     v6_q;
  logic [PixW-1:0]          p6_q;
  logic                     b6_q;
  logic                     sat6_q;
  logic [KW-1:0]            k6_q;
  logic [FixW-1:0]          pr_q, pg_q, pb_q;
  // output
  logic                     vo_q;
  logic [PixW-1:0]          po_q;

  logic signed [DeltaW-1:0]   dx_d, dy_d;
  logic signed [2*DeltaW-1:0] sqx_full, sqy_full;
  logic [DenW-1:0]            den_full;
  logic [PixW-1:0]            shade;

  assign dx_d = $signed({3'b000, in_item_i.column}) - DeltaW'(cfg_i.light_x);
  assign dy_d = $signed({3'b000, in_item_i.row}) - DeltaW'(cfg_i.light_y);
  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign den_full = DenW'({phi_q, 16'h0000}) + DenW'(plo_q) + DenW'(cfg_i.inv_int);

  always_comb begin
    logic [DivW-1:0] r_in;
    logic [KW-1:0]   q_in;
    logic [DivW-1:0] dv;
    logic [DivW:0]   t;
    for (int i = 0; i < KW; i++) begin
      if (i == 0) begin
        r_in = DivW'(65536);
        q_in = '0;
        dv   = den5_q;
      end else begin
        r_in = rem_q[i-1];
        q_in = quo_q[i-1];
        dv   = dend_q[i-1];
      end
      t = {r_in, 1'b0};
      if (t >= {1'b0, dv}) begin
        rem_d[i] = DivW'(t - {1'b0, dv});
        quo_d[i] = {q_in[KW-2:0], 1'b1};
      end else begin
        rem_d[i] = t[DivW-1:0];
        quo_d[i] = {q_in[KW-2:0], 1'b0};
      end
    end
  end

  function automatic logic [ColW-1:0] scale_byte(input logic sat, input logic [ColW-1:0] c,
                                                 input logic [FixW-1:0] p);
    logic [FixW:0] v;
    v = {1'b0, p} + (FixW+1)'(32768);
    if (sat) return (c != '0) ? 8'hFF : 8'h00;
    if (v[FixW:16] > 17'd255) return 8'hFF;
    return v[23:16];
  endfunction

  function automatic logic [ColW-1:0] alpha_byte(input logic sat, input logic [KW-1:0] k);
    logic [KW:0] v;
    v = (KW+1)'(255 << 16) - {1'b0, k} + (KW+1)'(32768);
    if (sat) return 8'h00;
    if (k >= KW'(255 << 16)) return 8'h00;
    return v[23:16];
  endfunction

  assign shade = {scale_byte(sat6_q, cfg_i.red, pr_q), scale_byte(sat6_q, cfg_i.green, pg_q),
                  scale_byte(sat6_q, cfg_i.blue, pb_q), alpha_byte(sat6_q, k6_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int i = 0; i < KW; i++) vd_q[i] <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vd_q[0] <= v5_q;
      for (int i = 1; i < KW; i++) vd_q[i] <= vd_q[i-1];
      v6_q <= vd_q[KW-1];
      vo_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= in_item_i.pixel;
      b1_q  <= in_item_i.bypass;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      p2_q  <= p1_q;
      b2_q  <= b1_q;
      sqx_q <= sqx_full[SqW-1:0];
      sqy_q <= sqy_full[SqW-1:0];
      p3_q  <= p2_q;
      b3_q  <= b2_q;
      d2_q  <= D2W'(sqx_q) + D2W'(sqy_q);
      p4_q  <= p3_q;
      b4_q  <= b3_q;
      plo_q <= cfg_i.scale * d2_q[15:0];
      phi_q <= cfg_i.scale * d2_q[D2W-1:16];
      p5_q  <= p4_q;
      b5_q  <= b4_q;
      sat5_q <= den_full <= DenW'(65536);
      den5_q <= (den_full > (DenW'(1) << 40)) ? '1 : den_full[DivW-1:0];
      pd_q[0]   <= p5_q;
      bd_q[0]   <= b5_q;
      satd_q[0] <= sat5_q;
      dend_q[0] <= den5_q;
      for (int i = 1; i < KW; i++) begin
        pd_q[i]   <= pd_q[i-1];
        bd_q[i]   <= bd_q[i-1];
        satd_q[i] <= satd_q[i-1];
        dend_q[i] <= dend_q[i-1];
      end
      for (int i = 0; i < KW; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
      p6_q   <= pd_q[KW-1];
      b6_q   <= bd_q[KW-1];
      sat6_q <= satd_q[KW-1];
      k6_q   <= quo_q[KW-1];
      pr_q   <= cfg_i.red * quo_q[KW-1];
      pg_q   <= cfg_i.green * quo_q[KW-1];
      pb_q   <= cfg_i.blue * quo_q[KW-1];
      po_q   <= b6_q ? p6_q : shade;
    end
  end

  assign out_valid_o = vo_q;
  assign out_pixel_o = po_q;

endmodule

// ----- src/point_light_pixel_shade.sv -----
// Top level of the point light pixel shader.
// Shades a stream of mask pixels with an inverse-square point light.
// Input channel s_axis_*: one transfer per pixel (mask word, column, row).
// Output channel m_axis_*: one transfer per input pixel, in input order.
// A nonzero mask word passes through unchanged; a zero word becomes
// {red, green, blue} scaled by k = 1 / (s * d^2 + q), with alpha 255 - k.
// Light parameters are written through cfg_we_i / cfg_idx_i / cfg_data_i
// while the stream is idle (the user must ensure this; the block does not
// enforce it); indexes 0..6 are light_x, light_y, scale, inverse intensity,
// red, green, blue. Throughput: one pixel per clock while the output is not
// stalled. From input transfer to output valid, a pixel passes the input register,
// the queue, the distance and denominator stages, the one-bit-per-stage
// reciprocal and the color product and output registers.
// The pipeline stalls as a whole while m_axis_tvalid is high and m_axis_tready
// is low; a four-entry queue keeps accepting input until it fills.
// Reset clears all valid flags and loads default light settings
// (light at origin, scale and inverse intensity 1.0, white light).
module point_light_pixel_shade import pls_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [FixW-1:0]  cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [InW-1:0]   s_axis_tdata,   // pixel_in[31:0], column[43:32], row[55:44]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [PixW-1:0]  m_axis_tdata    // pixel_out[31:0]
);

  light_cfg_t cfg_q;
  item_t      front_item, queue_item;
  logic       front_valid, queue_ready, queue_valid, back_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_x <= '0;
      cfg_q.light_y <= '0;
      cfg_q.scale   <= FixW'(32'h0100_0000);
      cfg_q.inv_int <= FixW'(32'h0100_0000);
      cfg_q.red     <= 8'hFF;
      cfg_q.green   <= 8'hFF;
      cfg_q.blue    <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLightX: cfg_q.light_x <= cfg_data_i[LightW-1:0];
        RegLightY: cfg_q.light_y <= cfg_data_i[LightW-1:0];
        RegScale:  cfg_q.scale   <= cfg_data_i;
        RegInvInt: cfg_q.inv_int <= cfg_data_i;
        RegRed:    cfg_q.red     <= cfg_data_i[ColW-1:0];
        RegGreen:  cfg_q.green   <= cfg_data_i[ColW-1:0];
        RegBlue:   cfg_q.blue    <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  pls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (front_valid),
    .out_ready_i (queue_ready),
    .out_item_o  (front_item)
  );

  pls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (queue_item)
  );

  pls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (queue_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (queue_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata)
  );

endmodule

// ----- dv/point_light_pixel_shade_test.sv -----
// Testbench for the point light pixel shader: directed table plus random stream.
`timescale 1ns / 1ps
module point_light_pixel_shade_test;
  import pls_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned NumRandom     = 700;

  typedef struct {
    logic [PixW-1:0]   pixel;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic              known;
    logic [PixW-1:0]   shaded;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i = '0;
  logic [FixW-1:0]  cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [PixW-1:0]  m_axis_tdata;

  light_cfg_t       light;
  logic [PixW-1:0]  shaded_q[$];
  int unsigned      error_count = 0;
  int unsigned      idle_cycles = 0;
  logic             draining = 1'b0;

  point_light_pixel_shade u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ColW-1:0] scale_color(logic [ColW-1:0] c, logic [31:0] k);
    logic [63:0] v;
    v = (64'(c) * 64'(k) + 64'h8000) >> 16;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [ColW-1:0] alpha_of(logic [31:0] k);
    logic [63:0] full;
    logic [63:0] v;
    full = 64'd255 << 16;
    if (64'(k) >= full) return 8'd0;
    v = (full - 64'(k) + 64'h8000) >> 16;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [PixW-1:0] shade_pixel(logic [PixW-1:0] pix,
                                                  logic [CoordW-1:0] col,
                                                  logic [CoordW-1:0] row);
    longint signed   dx;
    longint signed   dy;
    logic [63:0]     d2;
    logic [63:0]     den;
    logic [63:0]     quo;
    logic [31:0]     k;
    if (pix != '0) return pix;
    dx = longint'(col) - longint'(light.light_x);
    dy = longint'(row) - longint'(light.light_y);
    d2 = 64'(dx * dx) + 64'(dy * dy);
    den = 64'(light.scale) * d2 + 64'(light.inv_int);
    if (den == '0) k = '1;
    else begin
      quo = (64'd1 << 40) / den;
      k = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    end
    return {scale_color(light.red, k), scale_color(light.green, k),
            scale_color(light.blue, k), alpha_of(k)};
  endfunction

  task automatic report_mismatch(string what, logic [PixW-1:0] got, logic [PixW-1:0] want);
    $display("MISMATCH %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic write_light(logic [IdxW-1:0] idx, logic [FixW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegLightX: light.light_x = data[LightW-1:0];
      RegLightY: light.light_y = data[LightW-1:0];
      RegScale:  light.scale   = data;
      RegInvInt: light.inv_int = data;
      RegRed:    light.red     = data[ColW-1:0];
      RegGreen:  light.green   = data[ColW-1:0];
      RegBlue:   light.blue    = data[ColW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (shaded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Sender: bursts and gaps; tvalid held high across a burst.
  int unsigned burst_left = 0;
  task automatic send_pixel(logic [PixW-1:0] pix, logic [CoordW-1:0] col,
                            logic [CoordW-1:0] row);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col, pix};
    do @(posedge clk_i); while (!s_axis_tready);
    shaded_q.push_back(shade_pixel(pix, col, row));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // Receiver stall pattern: phases of always-ready and random stalls.
  int unsigned rx_phase = 0;
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (rx_phase[8]) m_axis_tready <= 1'b1;
    else if (rx_phase[6]) m_axis_tready <= ($urandom_range(0, 7) == 0);
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (shaded_q.size() == 0) report_mismatch("unexpected transfer", m_axis_tdata, '0);
      else begin
        if (m_axis_tdata !== shaded_q[0])
          report_mismatch("pixel_out", m_axis_tdata, shaded_q[0]);
        void'(shaded_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !draining) begin
      $display("Some tests failed");
      $finish;
    end
  end

  stim_row_t directed[] = '{
    '{32'h0000_0000, 12'd0,    12'd0,    1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF, 12'd5,    12'd7,    1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0001, 12'd4095, 12'd4095, 1'b1, 32'h0000_0001},
    '{32'h8000_0000, 12'd0,    12'd0,    1'b1, 32'h8000_0000},
    '{32'h0000_0000, 12'd1,    12'd0,    1'b0, '0},
    '{32'h0000_0000, 12'd4095, 12'd4095, 1'b0, '0},
    '{32'h0000_0000, 12'd4095, 12'd0,    1'b0, '0},
    '{32'h0000_0000, 12'd0,    12'd4095, 1'b0, '0},
    '{32'h0000_0000, 12'd3,    12'd4,    1'b0, '0},
    '{32'h0000_0000, 12'd2730, 12'd1365, 1'b0, '0},
    '{32'h5555_AAAA, 12'd1365, 12'd2730, 1'b1, 32'h5555_AAAA}
  };

  task automatic random_light();
    write_light(RegLightX, 32'($urandom_range(0, 16383)));
    write_light(RegLightY, 32'($urandom_range(0, 16383)));
    case ($urandom_range(0, 3))
      0: write_light(RegScale, 32'($urandom_range(0, 255)));
      1: write_light(RegScale, $urandom() >> $urandom_range(0, 31));
      2: write_light(RegScale, 32'hFFFF_FFFF);
      default: write_light(RegScale, '0);
    endcase
    case ($urandom_range(0, 3))
      0: write_light(RegInvInt, 32'($urandom_range(0, 255)));
      1: write_light(RegInvInt, $urandom() >> $urandom_range(0, 31));
      2: write_light(RegInvInt, 32'hFFFF_FFFF);
      default: write_light(RegInvInt, 32'h0100_0000);
    endcase
    write_light(RegRed,   32'($urandom_range(0, 255)));
    write_light(RegGreen, 32'($urandom_range(0, 255)));
    write_light(RegBlue,  32'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [PixW-1:0]   pix;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    light = '{light_x: '0, light_y: '0, scale: 32'h0100_0000, inv_int: 32'h0100_0000,
              red: 8'hFF, green: 8'hFF, blue: 8'hFF};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_pixel(directed[i].pixel, directed[i].column, directed[i].row);
      if (directed[i].known) shaded_q[$] = directed[i].shaded;
    end
    stop_sending();
    wait_idle();

    // Zero denominator: k saturates.
    write_light(RegScale, '0);
    write_light(RegInvInt, '0);
    write_light(RegRed, 32'd0);
    write_light(RegGreen, 32'd1);
    write_light(RegBlue, 32'd255);
    send_pixel('0, 12'd100, 12'd200);
    shaded_q[$] = 32'h00FF_FF00;
    // Extremes of light position.
    stop_sending();
    wait_idle();
    write_light(RegLightX, 32'h0000_2000);
    write_light(RegLightY, 32'h0000_1FFF);
    write_light(RegScale, 32'hFFFF_FFFF);
    write_light(RegInvInt, 32'hFFFF_FFFF);
    send_pixel('0, 12'd4095, 12'd0);
    send_pixel('0, 12'd0, 12'd4095);
    stop_sending();
    wait_idle();

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) begin
        stop_sending();
        wait_idle();
        random_light();
      end
      case ($urandom_range(0, 7))
        0: pix = $urandom();
        1: pix = 32'd1 << $urandom_range(0, 31);
        default: pix = '0;
      endcase
      col = $urandom_range(0, 4095);
      row = $urandom_range(0, 4095);
      if ($urandom_range(0, 1) == 0) begin
        col = 12'(light.light_x + $urandom_range(0, 8) - 4);
        row = 12'(light.light_y + $urandom_range(0, 8) - 4);
      end
      send_pixel(pix, col, row);
    end
    stop_sending();
    draining = 1'b1;
    for (int unsigned t = 0; t < WatchdogLimit && shaded_q.size() != 0; t++) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && shaded_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
